@@ hw/rtl/rgb_box_mean_filter_assert.svh @@
// Assertion macros for the box mean filter
`ifndef RGB_BOX_MEAN_FILTER_ASSERT_SVH
`define RGB_BOX_MEAN_FILTER_ASSERT_SVH
`ifndef SYNTH
`define RBMF_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rbmf assertion failed");
`define RBMF_ASSERT(lbl, prop) `RBMF_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define RBMF_ASSERT_CLK(lbl, clk, rstn, prop)
`define RBMF_ASSERT(lbl, prop)
`endif
`endif

@@ hw/rtl/rbmf_pkg.sv @@
package rbmf_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

  typedef struct packed {
    logic accept;
    logic setup;
    logic issue;
    logic div_step;
    logic emit;
  } rbmf_cmd_t;

  typedef struct packed {
    logic ready;
    logic win_last;
    logic div_done;
    logic out_free;
  } rbmf_stat_t;

endpackage

@@ hw/rtl/rbmf_ctrl.sv @@
module rbmf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rbmf_pkg::rbmf_stat_t stat_i,
  output rbmf_pkg::rbmf_cmd_t  cmd_o
);
  import rbmf_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_SUM   = 6'b000100,
    ST_FLUSH = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK: state_d = stat_i.ready ? ST_SUM : ST_IDLE;
      ST_SUM:   if (stat_i.win_last) state_d = ST_FLUSH;
      ST_FLUSH: state_d = ST_DIV;
      ST_DIV:   if (stat_i.div_done) state_d = ST_OUT;
      ST_OUT:   if (stat_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign cmd_o.accept   = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.setup    = (state_q == ST_CHECK);
  assign cmd_o.issue    = (state_q == ST_SUM);
  assign cmd_o.div_step = (state_q == ST_DIV) && !stat_i.div_done;
  assign cmd_o.emit     = (state_q == ST_OUT) && stat_i.out_free;

endmodule

@@ hw/rtl/rbmf_datapath.sv @@
module rbmf_datapath #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned MAX_RADIUS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rbmf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rbmf_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                mode_i,
  input  logic [3*rbmf_pkg::PIX_W-1:0]        pix_i,
  input  rbmf_pkg::rbmf_cmd_t                 cmd_i,
  output rbmf_pkg::rbmf_stat_t                stat_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [3*rbmf_pkg::PIX_W-1:0]        out_data_o,
  output logic                                out_last_o
);
  import rbmf_pkg::*;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
  localparam int unsigned SLOTS  = 2 * MAX_RADIUS + 2;
  localparam int unsigned DEPTH  = SLOTS * MAX_WIDTH;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int unsigned WIN    = 2 * MAX_RADIUS + 1;
  localparam int unsigned CNT_W  = $clog2(WIN * WIN + 1);
  localparam int unsigned SUM_W  = $clog2(255 * WIN * WIN + 1);
  localparam int unsigned DIVC_W = $clog2(SUM_W + 1);

  // config registers
  logic [10:0] w_cfg_q;
  logic [12:0] h_cfg_q;
  logic [2:0]  r_cfg_q;
  logic        restart;

  logic [31:0]      w32, h32, r32;
  logic [COL_W-1:0] wm1;
  logic [ROW_W-1:0] hm1;
  logic [RAD_W-1:0] rad;

  assign w32 = {21'd0, w_cfg_q};
  assign h32 = {19'd0, h_cfg_q};
  assign r32 = {29'd0, r_cfg_q};
  assign wm1 = (w32 == 32'd0) ? '0 :
               (w32 > MAX_WIDTH) ? COL_W'(MAX_WIDTH - 1) : COL_W'(w32 - 32'd1);
  assign hm1 = (h32 == 32'd0) ? '0 :
               (h32 > MAX_HEIGHT) ? ROW_W'(MAX_HEIGHT - 1) : ROW_W'(h32 - 32'd1);
  assign rad = (r32 > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(r32);

  assign restart = cfg_we_i && (cfg_idx_i == REG_WIDTH || cfg_idx_i == REG_HEIGHT ||
                                cfg_idx_i == REG_RADIUS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_cfg_q <= 11'd1024;
      h_cfg_q <= 13'd1024;
      r_cfg_q <= 3'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WIDTH:  w_cfg_q <= cfg_wdata_i[10:0];
        REG_HEIGHT: h_cfg_q <= cfg_wdata_i;
        REG_RADIUS: r_cfg_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // positions; base registers hold (row mod SLOTS) * MAX_WIDTH
  logic [COL_W-1:0] in_col_q, out_col_q;
  logic [ROW_W-1:0] in_row_q, out_row_q;
  logic [AW-1:0]    in_base_q, out_base_q;
  logic             frame_in_q;
  logic             wr_en;
  logic [AW:0]      in_base_nx, out_base_nx;

  assign wr_en       = cmd_i.accept && !mode_i && !frame_in_q;
  assign in_base_nx  = {1'b0, in_base_q} + (AW+1)'(MAX_WIDTH);
  assign out_base_nx = {1'b0, out_base_q} + (AW+1)'(MAX_WIDTH);

  logic last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_base_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_base_q <= '0;
      frame_in_q <= 1'b0;
    end else if (restart || (cmd_i.emit && last_q)) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_base_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_base_q <= '0;
      frame_in_q <= 1'b0;
    end else begin
      if (wr_en) begin
        if (in_col_q == wm1) begin
          in_col_q <= '0;
          if (in_row_q == hm1) begin
            in_row_q   <= '0;
            in_base_q  <= '0;
            frame_in_q <= 1'b1;
          end else begin
            in_row_q  <= in_row_q + 1'b1;
            in_base_q <= (in_base_nx >= (AW+1)'(DEPTH)) ? '0 : in_base_nx[AW-1:0];
          end
        end else begin
          in_col_q <= in_col_q + 1'b1;
        end
      end
      if (cmd_i.emit) begin
        if (out_col_q == wm1) begin
          out_col_q  <= '0;
          out_row_q  <= out_row_q + 1'b1;
          out_base_q <= (out_base_nx >= (AW+1)'(DEPTH)) ? '0 : out_base_nx[AW-1:0];
        end else begin
          out_col_q <= out_col_q + 1'b1;
        end
      end
    end
  end

  // line store
  logic [3*PIX_W-1:0] mem [DEPTH];
  logic [3*PIX_W-1:0] rd_q;
  logic               rd_vld_q;
  logic [AW-1:0]      wbase_q;
  logic [COL_W-1:0]   wx_q, wx0_q, wx1_q;
  logic [ROW_W-1:0]   wy_q, wy1_q;
  logic [AW-1:0]      rd_addr;

  assign rd_addr = wbase_q + AW'(wx_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[in_base_q + AW'(in_col_q)] <= pix_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr];
  end

  // window bounds and readiness
  logic [ROW_W:0]   need_row_w;
  logic [COL_W:0]   need_col_w;
  logic [ROW_W-1:0] need_row, y0, dy;
  logic [COL_W-1:0] need_col, x0;
  logic [AW:0]      off, wbase_init;

  always_comb begin
    need_row_w = {1'b0, out_row_q} + (ROW_W+1)'(rad);
    need_col_w = {1'b0, out_col_q} + (COL_W+1)'(rad);
    need_row   = (need_row_w > {1'b0, hm1}) ? hm1 : need_row_w[ROW_W-1:0];
    need_col   = (need_col_w > {1'b0, wm1}) ? wm1 : need_col_w[COL_W-1:0];
    y0 = (out_row_q >= ROW_W'(rad)) ? out_row_q - ROW_W'(rad) : '0;
    x0 = (out_col_q >= COL_W'(rad)) ? out_col_q - COL_W'(rad) : '0;
    dy = out_row_q - y0;
    off = (AW+1)'(dy) * (AW+1)'(MAX_WIDTH);
    wbase_init = {1'b0, out_base_q} - off;
    if ({1'b0, out_base_q} < off) begin
      wbase_init = wbase_init + (AW+1)'(DEPTH);
    end
  end

  assign stat_o.ready = frame_in_q || (in_row_q > need_row) ||
                        (in_row_q == need_row && in_col_q > need_col);
  assign stat_o.win_last = (wx_q == wx1_q) && (wy_q == wy1_q);

  logic [AW:0] wbase_nx;
  assign wbase_nx = {1'b0, wbase_q} + (AW+1)'(MAX_WIDTH);

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      wx0_q   <= x0;
      wx_q    <= x0;
      wx1_q   <= need_col;
      wy_q    <= y0;
      wy1_q   <= need_row;
      wbase_q <= wbase_init[AW-1:0];
      last_q  <= (out_row_q == hm1) && (out_col_q == wm1);
    end else if (cmd_i.issue) begin
      if (wx_q == wx1_q) begin
        wx_q    <= wx0_q;
        wy_q    <= wy_q + 1'b1;
        wbase_q <= (wbase_nx >= (AW+1)'(DEPTH)) ? '0 : wbase_nx[AW-1:0];
      end else begin
        wx_q <= wx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.issue;
    end
  end

  // accumulate, then restoring divide one quotient bit per cycle
  logic [SUM_W-1:0]  sum_q [3];
  logic [CNT_W-1:0]  rem_q [3];
  logic [CNT_W-1:0]  cnt_q;
  logic [DIVC_W-1:0] divc_q;

  always_ff @(posedge clk_i) begin
    logic [CNT_W:0] sh;
    if (cmd_i.setup) begin
      cnt_q  <= '0;
      divc_q <= '0;
      for (int c = 0; c < 3; c++) begin
        sum_q[c] <= '0;
        rem_q[c] <= '0;
      end
    end else if (rd_vld_q) begin
      cnt_q <= cnt_q + 1'b1;
      for (int c = 0; c < 3; c++) begin
        sum_q[c] <= sum_q[c] + SUM_W'(rd_q[c*PIX_W +: PIX_W]);
      end
    end else if (cmd_i.div_step) begin
      divc_q <= divc_q + 1'b1;
      for (int c = 0; c < 3; c++) begin
        sh = {rem_q[c], sum_q[c][SUM_W-1]};
        if (sh >= {1'b0, cnt_q}) begin
          rem_q[c] <= CNT_W'(sh - {1'b0, cnt_q});
          sum_q[c] <= {sum_q[c][SUM_W-2:0], 1'b1};
        end else begin
          rem_q[c] <= sh[CNT_W-1:0];
          sum_q[c] <= {sum_q[c][SUM_W-2:0], 1'b0};
        end
      end
    end
  end

  assign stat_o.div_done = (divc_q == DIVC_W'(SUM_W));

  // output register
  logic               out_vld_q;
  logic [3*PIX_W-1:0] out_data_q;
  logic               out_last_q;

  assign stat_o.out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      for (int c = 0; c < 3; c++) begin
        out_data_q[c*PIX_W +: PIX_W] <= sum_q[c][PIX_W-1:0];
      end
      out_last_q <= last_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

@@ hw/rtl/rgb_box_mean_filter.sv @@
// RGB box mean filter. Pixels enter in raster order; each result is the next
// output pixel in raster order, the per-channel truncated mean over its
// (2r+1)x(2r+1) window clipped to the image. An input item that makes no
// output ready passes through IDLE and CHECK only. One that releases an
// output then goes through SUM, which reads the P in-image window pixels
// (one line-store read per cycle through its single read port, up to 81 at
// radius 4), FLUSH, DIV, where the bit-serial divider forms a Q-bit quotient
// (15 bits at MAX_RADIUS 4), and OUT, which waits while the output is held
// off. Send drain items (tuser = 1) after the last pixel to flush the
// trailing outputs; tlast marks the final output of the frame. A write to
// any of the three registers restarts the frame. The line store has no reset
// and needs no initialization pass.
module rgb_box_mean_filter #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned MAX_RADIUS = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rbmf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rbmf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [23:0]                      s_axis_tdata,  // in_red, in_green, in_blue
  input  logic                             s_axis_tuser,  // mode
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [23:0]                      m_axis_tdata,  // out_red, out_green, out_blue
  output logic                             m_axis_tlast
);
  import rbmf_pkg::*;

  rbmf_cmd_t  cmd;
  rbmf_stat_t stat;

  rbmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rbmf_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mode_i      (s_axis_tuser),
    .pix_i       (s_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

`include "rgb_box_mean_filter_assert.svh"

  // a result is loaded only when the output register has room
  `RBMF_ASSERT(a_emit_room, cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
  // one item at a time: no new transaction right after one is taken
  `RBMF_ASSERT(a_one_item, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
  // a loaded result shows up on the master side next cycle
  `RBMF_ASSERT(a_emit_valid, cmd.emit |=> m_axis_tvalid)

endmodule
